>>> rtl/core/joint_play_window_tracker_macros.svh
// assertion macros shared by the joint play window tracker modules
`ifndef JOINT_PLAY_WINDOW_TRACKER_MACROS_SVH
`define JOINT_PLAY_WINDOW_TRACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define JPWT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define JPWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/jpwt_pkg.sv
// package with widths, constants and the per-joint entry type of the tracker
`timescale 1ns / 1ps

package jpwt_pkg;

    localparam int NUM_JOINTS_DEF = 32;
    localparam int JOINT_W        = 5;
    localparam int ANGLE_W        = 16;
    localparam int CHG_W          = 17;
    localparam int VAL_W          = 18;
    localparam int DIFF_W         = 19;
    localparam int PLAY_W         = 16;
    localparam int COUNT_W        = 16;
    localparam int RANGE_CMP_W    = 7;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [COUNT_W-1:0] WINDOW_RESET = 16'd100;

    // register index codes
    localparam logic [0:0] REG_WINDOW_FRAMES = 1'b0;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] prior;
        logic signed [CHG_W-1:0]   chg_lo;
        logic signed [CHG_W-1:0]   chg_hi;
        logic signed [VAL_W-1:0]   val_lo;
        logic signed [VAL_W-1:0]   val_hi;
        logic        [PLAY_W-1:0]  play;
    } entry_t;

endpackage

>>> rtl/core/jpwt_cfg.sv
// apb register block holding the window length
`timescale 1ns / 1ps

module jpwt_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [jpwt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [jpwt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [jpwt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [jpwt_pkg::COUNT_W-1:0]     window_frames
);
    import jpwt_pkg::*;

    logic [COUNT_W-1:0] window_reg;
    logic [COUNT_W-1:0] window_next;
    logic [0:0]         reg_idx;
    logic               wr_hit;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_hit  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        window_next = window_reg;
        prdata      = '0;
        unique case (reg_idx)
            REG_WINDOW_FRAMES:
            begin
                prdata = APB_DATA_W'(window_reg);
                if (wr_hit)
                begin
                    window_next = pwdata[COUNT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    assign window_frames = window_reg;

endmodule

>>> rtl/core/jpwt_store.sv
// per-joint state memory with valid bits and write-to-read forwarding
`timescale 1ns / 1ps
`include "joint_play_window_tracker_macros.svh"

module jpwt_store #(
    parameter int NUM_JOINTS = jpwt_pkg::NUM_JOINTS_DEF,
    parameter int AW         = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  jpwt_pkg::entry_t wr_data,
    output jpwt_pkg::entry_t rd_entry
);
    import jpwt_pkg::*;

    entry_t                mem [NUM_JOINTS];
    entry_t                rd_data_reg;
    entry_t                byp_data_reg;
    logic [NUM_JOINTS-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic                  byp_hit_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                byp_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // a write landing on the same edge as the read wins; unwritten entries read zero
    always_comb
    begin
        if (byp_hit_reg)
        begin
            rd_entry = byp_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_entry = rd_data_reg;
        end
        else
        begin
            rd_entry = '0;
        end
    end

    `JPWT_ASSERT_NEXT(a_byp_hold, !rd_en, $stable(byp_hit_reg), "bypass flag moved without a read")
    `JPWT_ASSERT_NEXT(a_wr_valid, wr_en, valid_reg[$past(wr_addr)], "written entry not marked valid")
    `JPWT_ASSERT_NEXT(a_byp_src, rd_en && wr_en && (wr_addr == rd_addr), byp_hit_reg,
        "same-entry write missed by forwarding")

endmodule

>>> rtl/core/jpwt_datapath.sv
// read-modify-write stage, frame counter and result register
`timescale 1ns / 1ps
`include "joint_play_window_tracker_macros.svh"

module jpwt_datapath #(
    parameter int NUM_JOINTS = jpwt_pkg::NUM_JOINTS_DEF,
    parameter int AW         = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic [jpwt_pkg::JOINT_W-1:0]        joint_number,
    input  logic signed [jpwt_pkg::ANGLE_W-1:0] measured_angle,
    input  logic signed [jpwt_pkg::ANGLE_W-1:0] requested_angle,
    input  logic                                clear_play,
    input  logic                                frame_end,
    input  logic [jpwt_pkg::COUNT_W-1:0]        window_frames,
    output logic                                rd_en,
    output logic [AW-1:0]                       rd_addr,
    input  jpwt_pkg::entry_t                    rd_entry,
    output logic                                wr_en,
    output logic [AW-1:0]                       wr_addr,
    output jpwt_pkg::entry_t                    wr_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [jpwt_pkg::JOINT_W-1:0]        joint_out,
    output logic [jpwt_pkg::PLAY_W-1:0]         play_value
);
    import jpwt_pkg::*;

    // stage 1 request
    logic                       s1_valid_reg;
    logic [JOINT_W-1:0]         s1_joint_reg;
    logic signed [ANGLE_W-1:0]  s1_meas_reg;
    logic signed [ANGLE_W-1:0]  s1_req_reg;
    logic                       s1_clr_reg;
    logic                       s1_fend_reg;

    logic                       primed_reg;
    logic                       primed_next;
    logic [COUNT_W-1:0]         frame_count_reg;
    logic [COUNT_W-1:0]         frame_count_next;

    logic                       out_valid_reg;
    logic [JOINT_W-1:0]         joint_out_reg;
    logic [PLAY_W-1:0]          play_out_reg;

    logic                       in_fire;
    logic                       s1_fire;
    logic                       in_range;
    logic [COUNT_W:0]           count;
    logic                       reached;
    logic signed [CHG_W-1:0]    chg;
    logic signed [VAL_W-1:0]    meas_ext;
    logic signed [VAL_W-1:0]    a_val;
    logic signed [VAL_W-1:0]    b_val;
    logic signed [DIFF_W-1:0]   diff;
    logic [PLAY_W-1:0]          sat;
    logic [PLAY_W-1:0]          play_base;
    entry_t                     upd;

    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || s1_fire;
    assign in_fire      = sample_valid && sample_ready;
    assign rd_en        = in_fire;
    assign rd_addr      = AW'(joint_number);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_joint_reg <= joint_number;
            s1_meas_reg  <= measured_angle;
            s1_req_reg   <= requested_angle;
            s1_clr_reg   <= clear_play;
            s1_fend_reg  <= frame_end;
        end
    end

    assign in_range = RANGE_CMP_W'(s1_joint_reg) < RANGE_CMP_W'(NUM_JOINTS);
    assign count    = {1'b0, frame_count_reg} + (COUNT_W + 1)'(primed_reg);
    assign reached  = count >= {1'b0, window_frames};
    assign meas_ext = VAL_W'(s1_meas_reg);

    always_comb
    begin
        upd       = rd_entry;
        chg       = CHG_W'(s1_req_reg) - CHG_W'(rd_entry.prior);
        a_val     = '0;
        b_val     = '0;
        diff      = '0;
        sat       = '0;
        play_base = s1_clr_reg ? '0 : rd_entry.play;
        upd.play  = play_base;
        if (primed_reg)
        begin
            if (chg < rd_entry.chg_lo)
            begin
                upd.chg_lo = chg;
            end
            if (chg > rd_entry.chg_hi)
            begin
                upd.chg_hi = chg;
            end
            a_val = meas_ext - VAL_W'(upd.chg_lo);
            b_val = meas_ext - VAL_W'(upd.chg_hi);
            if (a_val < rd_entry.val_lo)
            begin
                upd.val_lo = a_val;
            end
            if (b_val > rd_entry.val_hi)
            begin
                upd.val_hi = b_val;
            end
            diff = DIFF_W'(upd.val_hi) - DIFF_W'(upd.val_lo);
            // saturate the range to 0..65535
            if (diff < 0)
            begin
                sat = '0;
            end
            else if (diff[DIFF_W-1:PLAY_W] != '0)
            begin
                sat = '1;
            end
            else
            begin
                sat = diff[PLAY_W-1:0];
            end
            if (reached && (sat > play_base))
            begin
                upd.play = sat;
            end
        end
        else
        begin
            upd.val_lo = meas_ext;
            upd.val_hi = meas_ext;
        end
        if (reached)
        begin
            upd.chg_lo = '0;
            upd.chg_hi = '0;
            upd.val_lo = meas_ext;
            upd.val_hi = meas_ext;
        end
        upd.prior = s1_req_reg;
    end

    assign wr_en   = s1_fire && in_range;
    assign wr_addr = AW'(s1_joint_reg);
    assign wr_data = upd;

    always_comb
    begin
        primed_next      = primed_reg;
        frame_count_next = frame_count_reg;
        if (s1_fire && s1_fend_reg)
        begin
            primed_next      = 1'b1;
            frame_count_next = reached ? '0 : count[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg      <= 1'b0;
            frame_count_reg <= '0;
        end
        else
        begin
            primed_reg      <= primed_next;
            frame_count_reg <= frame_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            joint_out_reg <= s1_joint_reg;
            play_out_reg  <= in_range ? upd.play : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign joint_out    = joint_out_reg;
    assign play_value   = play_out_reg;

    `JPWT_ASSERT_NEXT(a_primed_sticky, primed_reg, primed_reg, "primed flag dropped")
    `JPWT_ASSERT_NEXT(a_count_hold, !(s1_fire && s1_fend_reg), $stable(frame_count_reg),
        "frame count moved without a frame end")
    `JPWT_ASSERT_IMPL(a_out_source, $rose(out_valid_reg), $past(s1_fire),
        "result appeared without a processed request")

endmodule

>>> rtl/core/joint_play_window_tracker.sv
// top level of the joint play window tracker
`timescale 1ns / 1ps

// joint play window tracker: takes one joint sample request per clock and
// returns one result per request (joint number and the joint's peak play,
// unsigned 16-bit in input angle units, saturated). throughput is one
// request per cycle with no gaps while result_ready holds, including
// back-to-back requests to the same joint. the per-joint entry is read from
// the state memory on the accepting edge, updated and written back when
// stage 1 fills the output register, where the result waits so a stalled
// consumer does not block the following request. an entry that was written
// on the same edge as a read is forwarded to that read. reset needs no
// clearing pass: one valid bit per joint makes never-written entries read
// as zero. window_frames is written through the apb port at byte address 0
// (reset value 100) and should only change while no request is in flight.

module joint_play_window_tracker #(
    parameter int NUM_JOINTS = jpwt_pkg::NUM_JOINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic [jpwt_pkg::JOINT_W-1:0]        joint_number,
    input  logic signed [jpwt_pkg::ANGLE_W-1:0] measured_angle,
    input  logic signed [jpwt_pkg::ANGLE_W-1:0] requested_angle,
    input  logic                                clear_play,
    input  logic                                frame_end,
    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [jpwt_pkg::JOINT_W-1:0]        joint_out,
    output logic [jpwt_pkg::PLAY_W-1:0]         play_value,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jpwt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [jpwt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [jpwt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import jpwt_pkg::*;

    // memory address width, at least one bit even for a single joint
    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    logic [COUNT_W-1:0] window_frames;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    entry_t             rd_entry;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;

    // window length register
    jpwt_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .window_frames (window_frames)
    );

    // per-joint state: last request, change range, value range, peak play
    jpwt_store #(
        .NUM_JOINTS (NUM_JOINTS),
        .AW         (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_entry (rd_entry)
    );

    // update stage, frame counting and result register
    jpwt_datapath #(
        .NUM_JOINTS (NUM_JOINTS),
        .AW         (AW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .joint_number    (joint_number),
        .measured_angle  (measured_angle),
        .requested_angle (requested_angle),
        .clear_play      (clear_play),
        .frame_end       (frame_end),
        .window_frames   (window_frames),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_entry        (rd_entry),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .joint_out       (joint_out),
        .play_value      (play_value)
    );

endmodule

>>> sim/joint_play_window_checker.sv
// checker that predicts and compares the tracker's results from the channel traffic
`timescale 1ns / 1ps

module joint_play_window_checker #(
    parameter int NUM_JOINTS = jpwt_pkg::NUM_JOINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    input  logic                                sample_ready,
    input  logic [jpwt_pkg::JOINT_W-1:0]        joint_number,
    input  logic signed [jpwt_pkg::ANGLE_W-1:0] measured_angle,
    input  logic signed [jpwt_pkg::ANGLE_W-1:0] requested_angle,
    input  logic                                clear_play,
    input  logic                                frame_end,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic [jpwt_pkg::JOINT_W-1:0]        joint_out,
    input  logic [jpwt_pkg::PLAY_W-1:0]         play_value,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [jpwt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [jpwt_pkg::APB_DATA_W-1:0]     pwdata,
    output int                                  fail_count,
    output int                                  pending_count
);

    localparam logic [jpwt_pkg::APB_ADDR_W-1:0] WINDOW_ADDR =
        jpwt_pkg::APB_ADDR_W'(4 * jpwt_pkg::REG_WINDOW_FRAMES);

    typedef struct packed {
        logic [jpwt_pkg::JOINT_W-1:0] joint;
        logic [jpwt_pkg::PLAY_W-1:0]  play;
    } play_result_t;

    // per-joint shadow of the tracker state
    logic signed [jpwt_pkg::ANGLE_W-1:0] last_request [NUM_JOINTS];
    logic signed [jpwt_pkg::CHG_W-1:0]   chg_min      [NUM_JOINTS];
    logic signed [jpwt_pkg::CHG_W-1:0]   chg_max      [NUM_JOINTS];
    logic signed [jpwt_pkg::VAL_W-1:0]   offset_min   [NUM_JOINTS];
    logic signed [jpwt_pkg::VAL_W-1:0]   offset_max   [NUM_JOINTS];
    logic        [jpwt_pkg::PLAY_W-1:0]  peak_play    [NUM_JOINTS];
    logic        [jpwt_pkg::COUNT_W-1:0] frames_seen;
    logic        [jpwt_pkg::COUNT_W-1:0] window_len;
    logic                                seeded;

    play_result_t play_expected_q [$];

    // applies one sample to the shadow state and returns the joint's play
    function automatic logic [jpwt_pkg::PLAY_W-1:0] track_joint_play(
        input logic [jpwt_pkg::JOINT_W-1:0]        j,
        input logic signed [jpwt_pkg::ANGLE_W-1:0] meas,
        input logic signed [jpwt_pkg::ANGLE_W-1:0] req,
        input logic                                clr,
        input logic                                fend
    );
        int                          count;
        bit                          reached;
        int                          chg;
        int                          lo_cand;
        int                          hi_cand;
        int                          spread;
        logic [jpwt_pkg::PLAY_W-1:0] play;
        count   = seeded ? int'(frames_seen) + 1 : int'(frames_seen);
        reached = count >= int'(window_len);
        play    = '0;
        if (int'(j) < NUM_JOINTS) begin
            if (clr)
                peak_play[j] = '0;
            if (seeded) begin
                chg = int'(req) - int'(last_request[j]);
                if (chg < int'(chg_min[j]))
                    chg_min[j] = jpwt_pkg::CHG_W'(chg);
                if (chg > int'(chg_max[j]))
                    chg_max[j] = jpwt_pkg::CHG_W'(chg);
                lo_cand = int'(meas) - int'(chg_min[j]);
                hi_cand = int'(meas) - int'(chg_max[j]);
                if (lo_cand < int'(offset_min[j]))
                    offset_min[j] = jpwt_pkg::VAL_W'(lo_cand);
                if (hi_cand > int'(offset_max[j]))
                    offset_max[j] = jpwt_pkg::VAL_W'(hi_cand);
                if (reached) begin
                    spread = int'(offset_max[j]) - int'(offset_min[j]);
                    if (spread < 0)
                        spread = 0;
                    if (spread > 65535)
                        spread = 65535;
                    if (spread > int'(peak_play[j]))
                        peak_play[j] = jpwt_pkg::PLAY_W'(spread);
                end
            end
            else begin
                offset_min[j] = jpwt_pkg::VAL_W'(meas);
                offset_max[j] = jpwt_pkg::VAL_W'(meas);
            end
            // window closed: ranges restart from this sample
            if (reached) begin
                chg_min[j]    = '0;
                chg_max[j]    = '0;
                offset_min[j] = jpwt_pkg::VAL_W'(meas);
                offset_max[j] = jpwt_pkg::VAL_W'(meas);
            end
            last_request[j] = req;
            play            = peak_play[j];
        end
        if (fend) begin
            frames_seen = reached ? '0 : jpwt_pkg::COUNT_W'(count);
            seeded      = 1'b1;
        end
        return play;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        play_result_t want;
        int           bad;
        if (!rst_n) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
                last_request[k] = '0;
                chg_min[k]      = '0;
                chg_max[k]      = '0;
                offset_min[k]   = '0;
                offset_max[k]   = '0;
                peak_play[k]    = '0;
            end
            frames_seen = '0;
            seeded      = 1'b0;
            window_len  = jpwt_pkg::WINDOW_RESET;
            play_expected_q.delete();
            pending_count <= 0;
            fail_count    <= 0;
        end
        else begin
            bad = 0;
            if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR)
                window_len = pwdata[jpwt_pkg::COUNT_W-1:0];
            if (sample_valid && sample_ready) begin
                want.joint = joint_number;
                want.play  = track_joint_play(joint_number, measured_angle,
                                              requested_angle, clear_play, frame_end);
                play_expected_q.push_back(want);
            end
            if (result_valid && result_ready) begin
                if (play_expected_q.size() == 0) begin
                    $error("result for joint %0d with no request outstanding", joint_out);
                    bad++;
                end
                else begin
                    want = play_expected_q.pop_front();
                    if (joint_out !== want.joint) begin
                        $error("joint_out: expected %0d, actual %0d", want.joint, joint_out);
                        bad++;
                    end
                    if (play_value !== want.play) begin
                        $error("play_value: expected %0d, actual %0d", want.play, play_value);
                        bad++;
                    end
                end
            end
            pending_count <= play_expected_q.size();
            fail_count    <= fail_count + bad;
        end
    end

endmodule

>>> sim/tb_joint_play_window_tracker.sv
// testbench top: request stimulus, configuration phases and the verdict
`timescale 1ns / 1ps

module tb_joint_play_window_tracker;

    localparam int JOINTS      = 32;
    localparam int QUIET_LIMIT = 500;
    localparam logic [jpwt_pkg::APB_ADDR_W-1:0] WINDOW_ADDR =
        jpwt_pkg::APB_ADDR_W'(4 * jpwt_pkg::REG_WINDOW_FRAMES);

    logic                                clk             = 1'b0;
    logic                                rst_n           = 1'b0;
    logic                                sample_valid    = 1'b0;
    logic                                sample_ready;
    logic [jpwt_pkg::JOINT_W-1:0]        joint_number    = '0;
    logic signed [jpwt_pkg::ANGLE_W-1:0] measured_angle  = '0;
    logic signed [jpwt_pkg::ANGLE_W-1:0] requested_angle = '0;
    logic                                clear_play      = 1'b0;
    logic                                frame_end       = 1'b0;
    logic                                result_valid;
    logic                                result_ready    = 1'b0;
    logic [jpwt_pkg::JOINT_W-1:0]        joint_out;
    logic [jpwt_pkg::PLAY_W-1:0]         play_value;
    logic                                psel            = 1'b0;
    logic                                penable         = 1'b0;
    logic                                pwrite          = 1'b0;
    logic [jpwt_pkg::APB_ADDR_W-1:0]     paddr           = '0;
    logic [jpwt_pkg::APB_DATA_W-1:0]     pwdata          = '0;
    logic [jpwt_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;

    int fail_count;
    int pending_count;

    // percent chance of an idle burst per request (sender) and per cycle (receiver)
    int idle_pct   = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    // last commanded angle per joint, keeps the smooth trajectories continuous
    int cmd_track [JOINTS];

    // random phases: window length, request count, longest frame, idle chance
    int phase_window [8] = '{3, 100, 65535, 2, 0, 1, 7, 5};
    int phase_items  [8] = '{200, 150, 100, 200, 80, 150, 200, 150};
    int phase_frame  [8] = '{4, 2, 6, 5, 8, 3, 6, 4};
    int phase_idle   [8] = '{15, 8, 25, 10, 20, 15, 8, 0};

    // 50 MHz clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    joint_play_window_tracker #(
        .NUM_JOINTS(JOINTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .joint_number   (joint_number),
        .measured_angle (measured_angle),
        .requested_angle(requested_angle),
        .clear_play     (clear_play),
        .frame_end      (frame_end),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .joint_out      (joint_out),
        .play_value     (play_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // the checker watches both channels and the register port beside the block
    joint_play_window_checker #(
        .NUM_JOINTS(JOINTS)
    ) play_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .joint_number   (joint_number),
        .measured_angle (measured_angle),
        .requested_angle(requested_angle),
        .clear_play     (clear_play),
        .frame_end      (frame_end),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .joint_out      (joint_out),
        .play_value     (play_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // result receiver: ready drops for bursts of random length at random,
    // independent of whether a result is waiting
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left   <= $urandom_range(1, 19) - 1;
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= 1'b1;
        end
    end

    // watchdog: too long without any request, result or register access ends the run
    always @(posedge clk) begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic int clamp_angle(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // offers one sample request, maybe after an idle burst, and returns on the
    // edge where it is taken; valid stays up so back-to-back requests need no gap
    task automatic send_sample(
        input logic [jpwt_pkg::JOINT_W-1:0]        j,
        input logic signed [jpwt_pkg::ANGLE_W-1:0] meas,
        input logic signed [jpwt_pkg::ANGLE_W-1:0] req,
        input logic                                clr,
        input logic                                fend
    );
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        sample_valid    <= 1'b1;
        joint_number    <= j;
        measured_angle  <= meas;
        requested_angle <= req;
        clear_play      <= clr;
        frame_end       <= fend;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // stops requests and waits until every expected result has come back;
    // the first edge lets the checker count a request taken on this edge
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_window(input logic [jpwt_pkg::COUNT_W-1:0] frames);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= jpwt_pkg::APB_DATA_W'(frames);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random frames: mostly smooth trajectories with a little backlash, plus
    // full-range noise, rail-to-rail jumps and held commands
    task automatic play_frames(input int n_items, input int frame_max);
        int                                  left;
        int                                  j;
        int                                  style;
        logic signed [jpwt_pkg::ANGLE_W-1:0] req_bits;
        logic signed [jpwt_pkg::ANGLE_W-1:0] meas_bits;
        left = 0;
        for (int n = 0; n < n_items; n++) begin
            if (left == 0)
                left = $urandom_range(1, frame_max);
            left--;
            j     = $urandom_range(0, JOINTS - 1);
            style = $urandom_range(0, 9);
            if (style < 6) begin
                req_bits  = 16'(clamp_angle(cmd_track[j] + int'($urandom_range(0, 1024)) - 512));
                meas_bits = 16'(clamp_angle(int'(req_bits) + int'($urandom_range(0, 256)) - 128));
            end
            else if (style < 8) begin
                req_bits  = 16'($urandom);
                meas_bits = 16'($urandom);
            end
            else if (style == 8) begin
                req_bits  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                meas_bits = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            else begin
                req_bits  = 16'(cmd_track[j]);
                meas_bits = 16'(clamp_angle(cmd_track[j] + int'($urandom_range(0, 64)) - 32));
            end
            cmd_track[j] = int'(req_bits);
            send_sample(j[jpwt_pkg::JOINT_W-1:0], meas_bits, req_bits,
                        $urandom_range(0, 15) == 0, left == 0);
        end
    endtask

    initial begin
        logic signed [jpwt_pkg::ANGLE_W-1:0] seed_req;
        logic signed [jpwt_pkg::ANGLE_W-1:0] seed_meas;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // seeding frame at the reset window: every joint gets a request
        // before the first frame end, so no primed sample ever reads an
        // unwritten prior request
        for (int j = 0; j < JOINTS; j++) begin
            seed_req  = 16'($urandom);
            seed_meas = 16'($urandom);
            if (j == 0) begin
                seed_req  = 16'sh0000;
                seed_meas = 16'sh8000;
            end
            else if (j == 1) begin
                seed_req  = 16'sh0000;
                seed_meas = 16'sh7fff;
            end
            cmd_track[j] = int'(seed_req);
            send_sample(j[jpwt_pkg::JOINT_W-1:0], seed_meas, seed_req, 1'b0, j == JOINTS - 1);
        end

        // one-frame window: full-scale change in both directions gives the
        // largest play, then a clear on a joint with no change drops it to zero
        settle();
        write_window(16'd1);
        send_sample(5'd0, 16'sh7fff, 16'sh8000, 1'b0, 1'b0);
        send_sample(5'd1, 16'sh8000, 16'sh7fff, 1'b1, 1'b1);
        send_sample(5'd1, 16'sh8000, 16'sh7fff, 1'b1, 1'b0);
        send_sample(5'd2, 16'sh0000, 16'sh0000, 1'b0, 1'b1);

        // zero window: every sample closes the window
        settle();
        write_window(16'd0);
        send_sample(5'd0, 16'sh8000, 16'sh7fff, 1'b0, 1'b0);
        send_sample(5'd3, 16'sh7fff, 16'sh8000, 1'b1, 1'b1);
        send_sample(5'd3, 16'sh0000, 16'sh0000, 1'b0, 1'b1);
        cmd_track[0] = 32767;
        cmd_track[1] = 32767;
        cmd_track[2] = 0;
        cmd_track[3] = 0;

        // random phases; the longest window lets the count run up so the window
        // that follows is lowered below it, the last phase runs without idling
        for (int p = 0; p < 8; p++) begin
            settle();
            write_window(phase_window[p][jpwt_pkg::COUNT_W-1:0]);
            idle_pct = phase_idle[p];
            play_frames(phase_items[p], phase_frame[p]);
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
